// ===== hw/rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_DEFAULT = 32;
    localparam int COORD_W      = 5;
    localparam int SIDE_CFG_W   = 6;
    localparam int COUNT_W      = 11;
    localparam int SIDE_MIN     = 2;

    localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RESET = 6'd32;
    localparam logic [COUNT_W-1:0]    COUNT_MAX       = 11'd2047;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_ADVANCE = 2'd3
    } kind_t;

endpackage

// ===== hw/rtl/life_grid_generation_step.sv =====
// Advance: one cell is evaluated per cycle in the column scan, plus a write-back
//   and a row load per row of the grid memory.
// Throughput: one request at a time; the next is taken when the FSM is idle,
//   even while the previous response still waits in the output register.
// Reset: grid reads as all dead at once (per-row valid bits), side = 32.
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded B3/S23 life grid held in a row-wide synchronous memory, with cell
// write/read, grid clear and a row-by-row generation step.
// ----------------------------------------------------------------------------
module life_grid_generation_step #(
    parameter int GRID = lgs_pkg::GRID_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lgs_pkg::SIDE_CFG_W-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lgs_pkg::kind_t                    kind,
    input  logic [lgs_pkg::COORD_W-1:0]       col,
    input  logic [lgs_pkg::COORD_W-1:0]       row,
    input  logic                              alive_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              alive_out,
    output logic [lgs_pkg::COUNT_W-1:0]       births,
    output logic [lgs_pkg::COUNT_W-1:0]       deaths
);
    import lgs_pkg::*;

    localparam int AW   = $clog2(GRID);
    localparam int SW   = $clog2(GRID + 1);
    localparam int XW   = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;
    localparam int CW0  = $clog2(GRID * GRID + 1);
    localparam int CNTW = (CW0 > COUNT_W) ? CW0 : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_WR_MOD,
        S_ADV_START,
        S_ADV_LOAD0,
        S_ADV_LOAD1,
        S_ADV_SCAN,
        S_ADV_WB,
        S_ADV_LOAD,
        S_PUSH
    } state_t;

    state_t                  state_reg;
    logic [SIDE_CFG_W-1:0]   grid_side_reg;
    logic [SW-1:0]           side_reg;
    logic [GRID-1:0]         row_valid_reg;
    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;
    logic                    alive_in_reg;
    logic [GRID-1:0]         above_reg;
    logic [GRID-1:0]         mid_reg;
    logic [GRID-1:0]         below_reg;
    logic [GRID-1:0]         new_row_reg;
    logic [AW-1:0]           r_reg;
    logic [AW-1:0]           c_reg;
    logic [CNTW-1:0]         born_cnt_reg;
    logic [CNTW-1:0]         died_cnt_reg;
    logic                    res_alive_reg;
    logic                    out_valid_reg;
    logic                    alive_out_reg;
    logic [COUNT_W-1:0]      births_reg;
    logic [COUNT_W-1:0]      deaths_reg;

    logic [GRID-1:0]         mem [GRID];
    logic [GRID-1:0]         mem_rdata_reg;
    logic                    rd_ok_reg;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [GRID-1:0]         mem_wdata;

    logic [XW-1:0]           side_ext;
    logic [SW-1:0]           side_next;
    logic                    in_range;
    logic [GRID-1:0]         side_mask;
    logic [GRID-1:0]         eff_rdata;
    logic [GRID-1:0]         wr_row;
    logic [AW-1:0]           col_idx;
    logic [GRID+1:0]         ext_above;
    logic [GRID+1:0]         ext_mid;
    logic [GRID+1:0]         ext_below;
    logic [2:0]              win_a;
    logic [2:0]              win_m;
    logic [2:0]              win_b;
    logic [3:0]              nbr;
    logic                    center;
    logic                    next_cell;
    logic                    last_col;
    logic                    last_row;
    logic                    next_row_exists;
    logic                    accept;
    logic                    push_fire;

    // side in use, saturated into 2..GRID
    always_comb
    begin
        side_ext = XW'(grid_side_reg);
        if (side_ext < XW'(SIDE_MIN))
            side_next = SW'(SIDE_MIN);
        else if (side_ext > XW'(GRID))
            side_next = SW'(GRID);
        else
            side_next = SW'(side_ext);
        in_range = (XW'(row) < XW'(side_next)) && (XW'(col) < XW'(side_next));
    end

    always_comb
    begin
        for (int i = 0; i < GRID; i++)
            side_mask[i] = (SW'(i) < side_reg);
    end

    assign eff_rdata = rd_ok_reg ? mem_rdata_reg : '0;
    assign col_idx   = AW'(col_reg);

    always_comb
    begin
        wr_row          = eff_rdata;
        wr_row[col_idx] = alive_in_reg;
    end

    // neighborhood window for the current column
    assign ext_above = {1'b0, above_reg & side_mask, 1'b0};
    assign ext_mid   = {1'b0, mid_reg & side_mask, 1'b0};
    assign ext_below = {1'b0, below_reg & side_mask, 1'b0};
    assign win_a     = ext_above[c_reg +: 3];
    assign win_m     = ext_mid[c_reg +: 3];
    assign win_b     = ext_below[c_reg +: 3];
    assign center    = win_m[1];
    assign nbr       = {3'b0, win_a[0]} + {3'b0, win_a[1]} + {3'b0, win_a[2]}
                     + {3'b0, win_m[0]} + {3'b0, win_m[2]}
                     + {3'b0, win_b[0]} + {3'b0, win_b[1]} + {3'b0, win_b[2]};
    assign next_cell = (nbr == 4'd3) || (center && (nbr == 4'd2));

    assign last_col        = (SW'(c_reg) == side_reg - SW'(1));
    assign last_row        = (SW'(r_reg) == side_reg - SW'(1));
    assign next_row_exists = ((SW+1)'(r_reg) + (SW+1)'(2)) < (SW+1)'(side_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign push_fire = (state_reg == S_PUSH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:      mem_raddr = AW'(row);
            S_ADV_START: mem_raddr = '0;
            S_ADV_LOAD0: mem_raddr = AW'(1);
            S_ADV_WB:    mem_raddr = AW'(r_reg + AW'(2));
            default:     mem_raddr = '0;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = r_reg;
        mem_wdata = new_row_reg;
        if (state_reg == S_WR_MOD)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(row_reg);
            mem_wdata = wr_row;
        end
        else if (state_reg == S_ADV_WB)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grid_side_reg <= GRID_SIDE_RESET;
            side_reg      <= SW'(GRID);
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            alive_in_reg  <= 1'b0;
            above_reg     <= '0;
            mid_reg       <= '0;
            below_reg     <= '0;
            new_row_reg   <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            born_cnt_reg  <= '0;
            died_cnt_reg  <= '0;
            res_alive_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            alive_out_reg <= 1'b0;
            births_reg    <= '0;
            deaths_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                grid_side_reg <= cfg_wr_data;

            rd_ok_reg <= row_valid_reg[mem_raddr];

            if (push_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        side_reg      <= side_next;
                        col_reg       <= col;
                        row_reg       <= row;
                        alive_in_reg  <= alive_in;
                        res_alive_reg <= 1'b0;
                        born_cnt_reg  <= '0;
                        died_cnt_reg  <= '0;
                        unique case (kind)
                            KIND_WRITE:   state_reg <= in_range ? S_WR_MOD : S_PUSH;
                            KIND_READ:    state_reg <= in_range ? S_RD_WAIT : S_PUSH;
                            KIND_CLEAR:
                            begin
                                row_valid_reg <= '0;
                                state_reg     <= S_PUSH;
                            end
                            KIND_ADVANCE: state_reg <= S_ADV_START;
                            default:      state_reg <= S_PUSH;
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    res_alive_reg <= eff_rdata[col_idx];
                    state_reg     <= S_PUSH;
                end
                S_WR_MOD:
                begin
                    row_valid_reg[AW'(row_reg)] <= 1'b1;
                    state_reg                   <= S_PUSH;
                end
                S_ADV_START:
                begin
                    r_reg     <= '0;
                    c_reg     <= '0;
                    above_reg <= '0;
                    state_reg <= S_ADV_LOAD0;
                end
                S_ADV_LOAD0:
                begin
                    mid_reg     <= eff_rdata;
                    new_row_reg <= eff_rdata;
                    state_reg   <= S_ADV_LOAD1;
                end
                S_ADV_LOAD1:
                begin
                    below_reg <= eff_rdata;
                    state_reg <= S_ADV_SCAN;
                end
                S_ADV_SCAN:
                begin
                    new_row_reg[c_reg] <= next_cell;
                    if (!center && next_cell)
                        born_cnt_reg <= born_cnt_reg + CNTW'(1);
                    if (center && !next_cell)
                        died_cnt_reg <= died_cnt_reg + CNTW'(1);
                    if (last_col)
                        state_reg <= S_ADV_WB;
                    else
                        c_reg <= c_reg + AW'(1);
                end
                S_ADV_WB:
                begin
                    // old rows r and r+1 stay in registers, so the snapshot is kept
                    row_valid_reg[r_reg] <= 1'b1;
                    above_reg            <= mid_reg;
                    mid_reg              <= below_reg;
                    new_row_reg          <= below_reg;
                    state_reg            <= last_row ? S_PUSH : S_ADV_LOAD;
                end
                S_ADV_LOAD:
                begin
                    below_reg <= next_row_exists ? eff_rdata : '0;
                    r_reg     <= r_reg + AW'(1);
                    c_reg     <= '0;
                    state_reg <= S_ADV_SCAN;
                end
                S_PUSH:
                begin
                    if (push_fire)
                    begin
                        alive_out_reg <= res_alive_reg;
                        births_reg    <= (born_cnt_reg > CNTW'(COUNT_MAX)) ?
                                         COUNT_MAX : born_cnt_reg[COUNT_W-1:0];
                        deaths_reg    <= (died_cnt_reg > CNTW'(COUNT_MAX)) ?
                                         COUNT_MAX : died_cnt_reg[COUNT_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign alive_out = alive_out_reg;
    assign births    = births_reg;
    assign deaths    = deaths_reg;

    a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
        (side_reg >= SW'(SIDE_MIN)) && (side_reg <= SW'(GRID)))
        else $error("side in use out of range");

    a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_SCAN) |-> ((SW'(c_reg) < side_reg) && (SW'(r_reg) < side_reg)))
        else $error("scan position outside grid");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && out_valid_reg && !out_ready) |=> (state_reg == S_PUSH))
        else $error("response dropped while output full");

    a_wb_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_WB && next_row_exists) |-> (mem_raddr != mem_waddr))
        else $error("write-back hits the row being loaded");

endmodule

// ===== test/life_grid_checker.sv =====
// ----------------------------------------------------------------------------
// life_grid_checker
// Watches the config port and both request/response channels of the life
// grid block, keeps its own copy of the grid and side, predicts the reply of
// every accepted request and compares it with the replies in order.
// ----------------------------------------------------------------------------
module life_grid_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lgs_pkg::SIDE_CFG_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  lgs_pkg::kind_t                 kind,
    input  logic [lgs_pkg::COORD_W-1:0]    col,
    input  logic [lgs_pkg::COORD_W-1:0]    row,
    input  logic                           alive_in,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           alive_out,
    input  logic [lgs_pkg::COUNT_W-1:0]    births,
    input  logic [lgs_pkg::COUNT_W-1:0]    deaths,
    output int                             mismatches,
    output int                             outstanding
);
    import lgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               alive;
        logic [COUNT_W-1:0] born;
        logic [COUNT_W-1:0] died;
    } cell_reply_t;

    logic [GRID_DEFAULT-1:0] cells [GRID_DEFAULT];
    logic [SIDE_CFG_W-1:0]   side_reg;
    cell_reply_t             replies_due [$];
    int                      err_count = 0;
    int                      due_count = 0;
    int                      reply_idx = 0;

    assign mismatches  = err_count;
    assign outstanding = due_count;

    function automatic int side_in_use();
        if (side_reg < SIDE_MIN)
            return SIDE_MIN;
        if (side_reg > GRID_DEFAULT)
            return GRID_DEFAULT;
        return int'(side_reg);
    endfunction

    // B3/S23 from a snapshot; neighbors outside the active square are dead
    function automatic void next_generation(input int sz,
                                            output logic [COUNT_W-1:0] born,
                                            output logic [COUNT_W-1:0] died);
        logic [GRID_DEFAULT-1:0] prev [GRID_DEFAULT];
        int nb;
        int b;
        int d;
        b = 0;
        d = 0;
        prev = cells;
        for (int r = 0; r < sz; r++)
        begin
            for (int c = 0; c < sz; c++)
            begin
                nb = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < sz
                            && c + dc >= 0 && c + dc < sz)
                            nb += prev[r+dr][c+dc];
                    end
                end
                if (prev[r][c])
                begin
                    if (nb != 2 && nb != 3)
                    begin
                        cells[r][c] = 1'b0;
                        d++;
                    end
                end
                else if (nb == 3)
                begin
                    cells[r][c] = 1'b1;
                    b++;
                end
            end
        end
        born = (b > COUNT_MAX) ? COUNT_MAX : COUNT_W'(b);
        died = (d > COUNT_MAX) ? COUNT_MAX : COUNT_W'(d);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] response %0d: %s got %0d want %0d", $time, reply_idx, what, got, want);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cell_reply_t want;
        int          sz;
        if (!rst_n)
        begin
            foreach (cells[i])
                cells[i] = '0;
            side_reg = GRID_SIDE_RESET;
            replies_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("response with nothing outstanding", 1, 0);
                else
                begin
                    want = replies_due.pop_front();
                    if (alive_out !== want.alive)
                        report_mismatch("alive_out", alive_out, want.alive);
                    if (births !== want.born)
                        report_mismatch("births", births, want.born);
                    if (deaths !== want.died)
                        report_mismatch("deaths", deaths, want.died);
                end
                reply_idx++;
            end
            if (in_valid && in_ready)
            begin
                sz = side_in_use();
                want = '0;
                case (kind)
                    KIND_WRITE:
                        if (int'(row) < sz && int'(col) < sz)
                            cells[row][col] = alive_in;
                    KIND_READ:
                        if (int'(row) < sz && int'(col) < sz)
                            want.alive = cells[row][col];
                    KIND_CLEAR:
                        foreach (cells[i])
                            cells[i] = '0;
                    default:
                        next_generation(sz, want.born, want.died);
                endcase
                replies_due.push_back(want);
            end
            if (cfg_wr_en)
                side_reg = cfg_wr_data;
            due_count <= replies_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the life grid block: directed cell, clear and generation requests
// over several grid sides, then random phases of seeding and stepping, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import lgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TARGET_REQS = 565;
    localparam int QUIET_FROM  = 490;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [SIDE_CFG_W-1:0] cfg_wr_data = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    kind_t                 kind        = KIND_READ;
    logic [COORD_W-1:0]    col         = '0;
    logic [COORD_W-1:0]    row         = '0;
    logic                  alive_in    = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  alive_out;
    logic [COUNT_W-1:0]    births;
    logic [COUNT_W-1:0]    deaths;

    int mismatches;
    int outstanding;
    int cycle_count    = 0;
    int requests_sent  = 0;
    int steps_sent     = 0;
    int sides_set      = 0;
    int cur_side       = GRID_DEFAULT;
    bit quiet_tail     = 1'b0;
    bit long_hold_done = 1'b0;

    always #4 clk = ~clk;

    life_grid_generation_step u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .col         (col),
        .row         (row),
        .alive_in    (alive_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .alive_out   (alive_out),
        .births      (births),
        .deaths      (deaths)
    );

    life_grid_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .col         (col),
        .row         (row),
        .alive_in    (alive_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .alive_out   (alive_out),
        .births      (births),
        .deaths      (deaths),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(input kind_t k, input int c, input int r, input bit a);
        kind     <= k;
        col      <= COORD_W'(c);
        row      <= COORD_W'(r);
        alive_in <= a;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (k == KIND_ADVANCE)
            steps_sent++;
        quiet_tail = (requests_sent >= QUIET_FROM);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // grid side changes only once every reply is back
    task automatic set_side(input int v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIDE_CFG_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_side = (v < SIDE_MIN) ? SIDE_MIN : (v > GRID_DEFAULT) ? GRID_DEFAULT : v;
        sides_set++;
    endtask

    function automatic int any_coord();
        return $urandom_range(0, GRID_DEFAULT - 1);
    endfunction

    function automatic int side_coord();
        return $urandom_range(0, cur_side - 1);
    endfunction

    task automatic random_phase();
        int pick;
        int seeds;
        int steps;
        int r;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            set_side($urandom_range(2, 8));
        else if (pick < 7)
            set_side($urandom_range(9, 20));
        else if (pick == 7)
            set_side(32);
        else if (pick == 8)
            set_side($urandom_range(0, 1) ? 0 : 63);
        else
            set_side($urandom_range(0, 63));
        if ($urandom_range(0, 2) == 0)
            send_req(KIND_CLEAR, any_coord(), any_coord(), $urandom_range(0, 1));
        seeds = $urandom_range(3, (cur_side * cur_side / 2 > 24) ? 24 : cur_side * cur_side / 2);
        repeat (seeds)
            send_req(KIND_WRITE, side_coord(), side_coord(), $urandom_range(0, 4) != 0);
        steps = $urandom_range(8, 20);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_req(KIND_ADVANCE, any_coord(), any_coord(), $urandom_range(0, 1));
            else if (r < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_req(KIND_READ, any_coord(), any_coord(), $urandom_range(0, 1));
                else
                    send_req(KIND_READ, side_coord(), side_coord(), $urandom_range(0, 1));
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_req(KIND_WRITE, any_coord(), any_coord(), $urandom_range(0, 1));
                else
                    send_req(KIND_WRITE, side_coord(), side_coord(), $urandom_range(0, 1));
            end
            else if (r < 88)
                send_req(KIND_CLEAR, any_coord(), any_coord(), $urandom_range(0, 1));
            else
                send_req(KIND_READ, any_coord(), any_coord(), $urandom_range(0, 1));
        end
    endtask

    initial
    begin : response_side
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && requests_sent >= 100)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (quiet_tail || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    initial
    begin : request_side
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // side 32 after reset: corner L-shape grows into a block, lone cell dies
        send_req(KIND_WRITE, 0, 0, 1'b1);
        send_req(KIND_WRITE, 0, 1, 1'b1);
        send_req(KIND_WRITE, 1, 0, 1'b1);
        send_req(KIND_WRITE, 31, 31, 1'b1);
        send_req(KIND_WRITE, 30, 31, 1'b0);
        send_req(KIND_READ, 31, 31, 1'b0);
        send_req(KIND_READ, 0, 0, 1'b0);
        send_req(KIND_ADVANCE, 0, 0, 1'b0);
        send_req(KIND_READ, 1, 1, 1'b0);
        send_req(KIND_WRITE, 20, 20, 1'b1);

        // small side: outside writes ignored, outside reads zero, edge blinker
        set_side(4);
        send_req(KIND_WRITE, 5, 5, 1'b1);
        send_req(KIND_READ, 5, 5, 1'b0);
        send_req(KIND_WRITE, 3, 1, 1'b1);
        send_req(KIND_WRITE, 3, 2, 1'b1);
        send_req(KIND_WRITE, 3, 3, 1'b1);
        send_req(KIND_ADVANCE, 31, 31, 1'b1);
        send_req(KIND_READ, 20, 20, 1'b0);

        // sides below the minimum saturate to 2
        set_side(0);
        send_req(KIND_ADVANCE, 0, 0, 1'b0);
        set_side(1);
        send_req(KIND_READ, 1, 1, 1'b0);

        // sides above the grid saturate; cell beyond the small side kept its value
        set_side(63);
        send_req(KIND_READ, 20, 20, 1'b0);
        send_req(KIND_ADVANCE, 0, 0, 1'b0);
        set_side(33);
        send_req(KIND_CLEAR, 31, 31, 1'b1);
        send_req(KIND_READ, 0, 0, 1'b0);
        send_req(KIND_WRITE, 31, 31, 1'b1);
        send_req(KIND_READ, 31, 31, 1'b1);

        while (requests_sent < TARGET_REQS)
            random_phase();

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d requests, %0d generation steps, %0d side settings",
                 requests_sent, steps_sent, sides_set);
        $display("random idling on both channels plus one long response stall");
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== life_grid_generation_step.f =====
hw/rtl/lgs_pkg.sv
hw/rtl/life_grid_generation_step.sv
test/life_grid_checker.sv
test/tb_top.sv
